// ===== rtl/core/waveform_column_span_render_macros.svh =====
// ----------------------------------------------------------------------------
// waveform column span render assertion macros
// shared concurrent check forms, clocked on clk and gated by reset
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_COLUMN_SPAN_RENDER_MACROS_SVH
`define WAVEFORM_COLUMN_SPAN_RENDER_MACROS_SVH

// same-cycle implication
`define WCSR_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WCSR_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/wcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// wcsr_pkg
// types, register map and helpers shared by the span render blocks
// ----------------------------------------------------------------------------
package wcsr_pkg;

	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;
	localparam int LEVEL_W = 12;
	localparam int ROW_W   = 12;
	localparam int DIM_W   = 13;
	localparam int ZOOM_W  = 48;

	localparam logic [DIM_W-1:0] ROWS_CAP = 13'd4096;

	localparam logic [2:0] REG_START  = 3'd0;
	localparam logic [2:0] REG_ZOOM   = 3'd1;
	localparam logic [2:0] REG_WIDTH  = 3'd2;
	localparam logic [2:0] REG_HEIGHT = 3'd3;
	localparam logic [2:0] REG_WIDE   = 3'd4;

	typedef struct packed {
		logic [23:0]       start_position;
		logic [ZOOM_W-1:0] zoom_step;
		logic [DIM_W-1:0]  view_width;
		logic [DIM_W-1:0]  view_height;
		logic              wide_samples;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		start_position: 24'd0,
		zoom_step:      48'd16777216,
		view_width:     13'd1024,
		view_height:    13'd256,
		wide_samples:   1'b1
	};

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last;
	} item_t;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_LOOP,
		PH_FIN
	} phase_t;

	function automatic logic [DIM_W-1:0] rows_of(input logic [DIM_W-1:0] h);
		logic [DIM_W-1:0] r;
		r = h;
		if (h == '0) begin
			r = 13'd1;
		end else if (h > ROWS_CAP) begin
			r = ROWS_CAP;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/waveform_column_span_render.sv =====
// ----------------------------------------------------------------------------
// waveform_column_span_render
// min/max decimated waveform view: samples in, one vertical span per column
// ----------------------------------------------------------------------------
// Samples are taken at one per cycle while the span sequencer and the output
// do not stall. A sample that causes two or more spans (zoomed in below one
// sample per column, or a stream end inside a column right after a column
// close) holds the input until the span sequencer, which emits one span per
// cycle while the output is free through a single pending-span register and
// one output register, has released the last of them from the pending-span
// register. Output stalls add to this. A single span passes the input, level
// and output registers; the first of several spans also waits in the pending-
// span register. end_of_run marks the last span of each input beat. Registers
// must be written only while the block is idle; the block does not enforce this.
module waveform_column_span_render import wcsr_pkg::*; #(
	parameter int MAX_COLUMNS   = 4096,
	parameter int INDEX_BITS    = 24,
	parameter int FRACTION_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       sample_value,
	input  logic              final_sample,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROW_W-1:0]  column,
	output logic [ROW_W-1:0]  row_top,
	output logic [ROW_W-1:0]  row_bottom,
	output logic              end_of_run
);

	cfg_t  cfg;
	item_t item;
	logic  item_valid;
	logic  item_take;

	wcsr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wcsr_level u_level (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.final_sample (final_sample),
		.view_height  (cfg.view_height),
		.wide_samples (cfg.wide_samples),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take)
	);

	wcsr_span #(
		.MAX_COLUMNS   (MAX_COLUMNS),
		.INDEX_BITS    (INDEX_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_span (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.column     (column),
		.row_top    (row_top),
		.row_bottom (row_bottom),
		.end_of_run (end_of_run)
	);

endmodule

// ===== rtl/core/wcsr_cfg.sv =====
// ----------------------------------------------------------------------------
// wcsr_cfg
// apb register file for view position, zoom and geometry
// ----------------------------------------------------------------------------
module wcsr_cfg import wcsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr) begin
			case (paddr[ADDR_W-1:3])
				REG_START:  cfg_q.start_position <= pwdata[23:0];
				REG_ZOOM:   cfg_q.zoom_step      <= pwdata[ZOOM_W-1:0];
				REG_WIDTH:  cfg_q.view_width     <= pwdata[DIM_W-1:0];
				REG_HEIGHT: cfg_q.view_height    <= pwdata[DIM_W-1:0];
				REG_WIDE:   cfg_q.wide_samples   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:3])
			REG_START:  prdata = DATA_W'(cfg_q.start_position);
			REG_ZOOM:   prdata = DATA_W'(cfg_q.zoom_step);
			REG_WIDTH:  prdata = DATA_W'(cfg_q.view_width);
			REG_HEIGHT: prdata = DATA_W'(cfg_q.view_height);
			REG_WIDE:   prdata = DATA_W'(cfg_q.wide_samples);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/wcsr_level.sv =====
// ----------------------------------------------------------------------------
// wcsr_level
// input register and level scaling: offset-binary sample times view height
// ----------------------------------------------------------------------------
module wcsr_level import wcsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [15:0]      sample_value,
	input  logic             final_sample,
	input  logic [DIM_W-1:0] view_height,
	input  logic             wide_samples,
	output logic             item_valid,
	output item_t            item,
	input  logic             item_take
);

	logic        v_s1;
	logic [15:0] smp_s1;
	logic        fin_s1;
	logic        v_s2;
	item_t       item_s2;

	logic                   adv;
	logic                   take;
	logic [15:0]            u;
	logic [DIM_W-1:0]       h;
	logic [15+DIM_W:0]      prod;

	assign adv      = v_s1 & (~v_s2 | item_take);
	assign in_ready = ~v_s1 | adv;
	assign take     = in_valid & in_ready;

	// 8-bit samples sit in the upper byte so one product serves both widths
	assign u    = wide_samples ? {~smp_s1[15], smp_s1[14:0]}
	                           : {~smp_s1[7], smp_s1[6:0], 8'h00};
	assign h    = rows_of(view_height);
	assign prod = (16 + DIM_W)'(u) * (16 + DIM_W)'(h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (item_take) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			smp_s1 <= sample_value;
			fin_s1 <= final_sample;
		end
		if (adv) begin
			item_s2.level <= prod[27:16];
			item_s2.last  <= fin_s1;
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;

endmodule

// ===== rtl/core/wcsr_span.sv =====
// ----------------------------------------------------------------------------
// wcsr_span
// column sequencer: tracks column bounds, min/max levels and emits spans
// ----------------------------------------------------------------------------
`include "waveform_column_span_render_macros.svh"

module wcsr_span import wcsr_pkg::*; #(
	parameter int MAX_COLUMNS   = 4096,
	parameter int INDEX_BITS    = 24,
	parameter int FRACTION_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             item_valid,
	input  item_t            item,
	output logic             item_take,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ROW_W-1:0] column,
	output logic [ROW_W-1:0] row_top,
	output logic [ROW_W-1:0] row_bottom,
	output logic             end_of_run
);

	localparam int CB = $clog2(MAX_COLUMNS + 1);
	localparam int WB = (CB > DIM_W) ? CB : DIM_W;
	localparam int TW = ZOOM_W - FRACTION_BITS + 1;
	localparam int SW = (TW > INDEX_BITS) ? TW : INDEX_BITS;
	localparam logic [ZOOM_W-1:0]     ZOOM_LEAST = ZOOM_W'(1) << (FRACTION_BITS - 5);
	localparam logic [INDEX_BITS-1:0] IDX_MASK   = '1;

	logic [INDEX_BITS-1:0]    cnt_q;
	logic [CB-1:0]            col_q, col_a, col_b, span_col;
	logic [INDEX_BITS:0]      end_q, end_b, end_new, first_idx, s_ext;
	logic [FRACTION_BITS-1:0] frac_q, frac_b;
	logic [LEVEL_W-1:0]       min_q, max_q, mn_a, mx_a, mn_b, mx_b, span_mn, span_mx;
	logic                     open_q, open_a, open_b, done_q, done_b;
	phase_t                   phase_q, phase_d;

	logic emit_a, emit_b, emit_c, emit;
	logic iter_ok, defer, do_iter, loop_more, need_part, last_step, go;

	logic [WB-1:0]            w_lim;
	logic [DIM_W-1:0]         h;
	logic [ZOOM_W-1:0]        z;
	logic [FRACTION_BITS:0]   frac_sum;
	logic [TW-1:0]            t_full;
	logic [INDEX_BITS-1:0]    t;
	logic                     t0;
	logic [ROW_W-1:0]         span_top, span_bot;

	logic             hold_v_q, hold_last_q, hold_v_d, hold_last_d, hold_load;
	logic [ROW_W-1:0] hold_col_q, hold_top_q, hold_bot_q;
	logic             out_v_q, out_v_d, out_load, out_eor, out_free, flush;
	logic [ROW_W-1:0] out_col_q, out_top_q, out_bot_q;
	logic             out_eor_q;

	assign h     = rows_of(cfg.view_height);
	assign w_lim = (WB'(cfg.view_width) > WB'(MAX_COLUMNS)) ? WB'(MAX_COLUMNS)
	                                                         : WB'(cfg.view_width);

	// column step from the zoom, clamped below at one thirty-second
	assign z        = (cfg.zoom_step < ZOOM_LEAST) ? ZOOM_LEAST : cfg.zoom_step;
	assign frac_sum = {1'b0, frac_q} + {1'b0, z[FRACTION_BITS-1:0]};
	assign t_full   = {1'b0, z[ZOOM_W-1:FRACTION_BITS]} + TW'(frac_sum[FRACTION_BITS]);
	assign t        = (SW'(t_full) > SW'(IDX_MASK)) ? IDX_MASK : INDEX_BITS'(t_full);
	assign t0       = (t == '0);
	assign s_ext    = {1'b0, cnt_q};
	assign end_new  = s_ext + {1'b0, t};

	always_comb begin
		mn_a   = min_q;
		mx_a   = max_q;
		open_a = open_q;
		col_a  = col_q;
		emit_a = 1'b0;
		// close the open column on its end sample
		if (phase_q == PH_FIRST && !done_q && open_q) begin
			mn_a = (item.level < min_q) ? item.level : min_q;
			mx_a = (item.level > max_q) ? item.level : max_q;
			if (s_ext == end_q) begin
				emit_a = 1'b1;
				open_a = 1'b0;
				col_a  = col_q + CB'(1);
			end
		end

		first_idx = (col_a == '0) ? {1'b0, INDEX_BITS'(cfg.start_position)} : end_q;
		iter_ok   = (phase_q != PH_FIN) && !done_q && !open_a
		            && (WB'(col_a) < w_lim) && (s_ext == first_idx);
		defer     = iter_ok && emit_a && t0;
		do_iter   = iter_ok && !defer;

		mn_b   = mn_a;
		mx_b   = mx_a;
		open_b = open_a;
		col_b  = col_a;
		end_b  = end_q;
		frac_b = frac_q;
		emit_b = 1'b0;
		// open the next column here, or emit it at once when its step is zero
		if (do_iter) begin
			frac_b = frac_sum[FRACTION_BITS-1:0];
			end_b  = end_new;
			mn_b   = item.level;
			mx_b   = item.level;
			if (t0) begin
				emit_b = 1'b1;
				col_b  = col_a + CB'(1);
			end else begin
				open_b = 1'b1;
			end
		end

		done_b    = done_q || (WB'(col_b) >= w_lim);
		loop_more = !done_b && (defer || (do_iter && t0));
		// partial span when the stream ends inside a column
		need_part = item.last && open_b && !done_b;
		emit_c    = !loop_more && need_part && (phase_q == PH_FIN || !(emit_a || emit_b));
		last_step = !loop_more && !(need_part && !emit_c);
		emit      = emit_a | emit_b | emit_c;

		if (emit_a) begin
			span_col = col_q;
			span_mn  = mn_a;
			span_mx  = mx_a;
		end else if (emit_b) begin
			span_col = col_a;
			span_mn  = item.level;
			span_mx  = item.level;
		end else begin
			span_col = col_b;
			span_mn  = mn_b;
			span_mx  = mx_b;
		end
		span_top = ROW_W'(h - DIM_W'(1) - DIM_W'(span_mx));
		span_bot = ROW_W'(h - DIM_W'(1) - DIM_W'(span_mn));

		if (!go) begin
			phase_d = phase_q;
		end else if (last_step) begin
			phase_d = PH_FIRST;
		end else if (loop_more) begin
			phase_d = PH_LOOP;
		end else begin
			phase_d = PH_FIN;
		end
	end

	// one pending span waits until it is known whether more follow
	assign out_free  = ~out_v_q | out_ready;
	assign go        = item_valid & out_free & ~hold_last_q;
	assign item_take = go & last_step;
	assign flush     = hold_last_q & out_free;
	assign out_load  = flush | (go & ((hold_v_q & (emit | last_step))
	                                  | (~hold_v_q & emit & last_step)));
	assign out_eor   = flush | ~(hold_v_q & emit);
	assign hold_load = go & emit & (hold_v_q | ~last_step);

	always_comb begin
		if (hold_load) begin
			hold_v_d = 1'b1;
		end else if (flush || (go && last_step)) begin
			hold_v_d = 1'b0;
		end else begin
			hold_v_d = hold_v_q;
		end
		if (hold_load) begin
			hold_last_d = last_step;
		end else if (flush) begin
			hold_last_d = 1'b0;
		end else begin
			hold_last_d = hold_last_q;
		end
		if (out_load) begin
			out_v_d = 1'b1;
		end else if (out_ready) begin
			out_v_d = 1'b0;
		end else begin
			out_v_d = out_v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			cnt_q       <= '0;
			col_q       <= '0;
			end_q       <= '0;
			frac_q      <= '0;
			min_q       <= '0;
			max_q       <= '0;
			open_q      <= 1'b0;
			done_q      <= 1'b0;
			hold_v_q    <= 1'b0;
			hold_last_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			hold_v_q    <= hold_v_d;
			hold_last_q <= hold_last_d;
			out_v_q     <= out_v_d;
			if (go) begin
				if (last_step && item.last) begin
					cnt_q  <= '0;
					col_q  <= '0;
					end_q  <= '0;
					frac_q <= '0;
					min_q  <= '0;
					max_q  <= '0;
					open_q <= 1'b0;
					done_q <= 1'b0;
				end else begin
					col_q  <= col_b;
					end_q  <= end_b;
					frac_q <= frac_b;
					min_q  <= mn_b;
					max_q  <= mx_b;
					open_q <= open_b;
					done_q <= done_b;
					if (last_step) begin
						cnt_q <= cnt_q + INDEX_BITS'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_load) begin
			hold_col_q <= ROW_W'(span_col);
			hold_top_q <= span_top;
			hold_bot_q <= span_bot;
		end
		if (out_load) begin
			out_eor_q <= out_eor;
			if (flush || hold_v_q) begin
				out_col_q <= hold_col_q;
				out_top_q <= hold_top_q;
				out_bot_q <= hold_bot_q;
			end else begin
				out_col_q <= ROW_W'(span_col);
				out_top_q <= span_top;
				out_bot_q <= span_bot;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign column     = out_col_q;
	assign row_top    = out_top_q;
	assign row_bottom = out_bot_q;
	assign end_of_run = out_eor_q;

	`WCSR_CHECK(a_hold_last_valid, hold_last_q, hold_v_q, "closing span held without hold valid")
	`WCSR_CHECK(a_open_not_done, open_q, !done_q, "column open in a finished frame")
	`WCSR_CHECK(a_fin_phase, phase_q == PH_FIN, open_q && !done_q, "partial span phase without open column")
	`WCSR_CHECK(a_hold_mid_item, hold_v_q && !hold_last_q, phase_q != PH_FIRST, "pending span outlived its sample")
	`WCSR_CHECK_NEXT(a_emit_lands, go && emit, out_v_q || hold_v_q, "emitted span lost")

endmodule

// ===== tb/sv/tb_waveform_column_span_render.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_waveform_column_span_render
// Streams sample waveforms through the span renderer under a range of view
// and zoom settings. Each accepted sample is run through a local model of the
// column walk, and the spans it yields are queued. Every span the block
// returns is checked field by field against the oldest queued span.
// ----------------------------------------------------------------------------
module tb_waveform_column_span_render;
	import wcsr_pkg::*;

	localparam longint unsigned INDEX_MASK = 64'hFF_FFFF;
	localparam longint unsigned FRAC_ONE   = 64'h100_0000;
	localparam longint unsigned ZOOM_FLOOR = FRAC_ONE >> 5;
	localparam longint unsigned COLS_CAP   = 4096;
	localparam int STALL_LIMIT   = 1000;
	localparam int HOLD_CYCLES   = 150;
	localparam int SAMPLE_TARGET = 330;

	typedef struct {
		logic [11:0] column;
		logic [11:0] row_top;
		logic [11:0] row_bottom;
		logic        end_of_run;
	} span_t;

	class span_scoreboard;
		cfg_t            cfg;
		longint unsigned smp_idx;
		longint unsigned cols_done;
		longint unsigned col_end;
		longint unsigned frac_acc;
		int unsigned     lvl_lo;
		int unsigned     lvl_hi;
		bit              col_open;
		bit              frame_done;
		span_t           held;
		bit              have_held;
		span_t           spans_due[$];
		int              errors;

		function new();
			cfg = CFG_RESET;
			errors = 0;
			have_held = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			smp_idx = 0;
			cols_done = 0;
			col_end = 0;
			frac_acc = 0;
			lvl_lo = 0;
			lvl_hi = 0;
			col_open = 0;
			frame_done = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_START:  cfg.start_position = val[23:0];
				REG_ZOOM:   cfg.zoom_step = val[47:0];
				REG_WIDTH:  cfg.view_width = val[12:0];
				REG_HEIGHT: cfg.view_height = val[12:0];
				REG_WIDE:   cfg.wide_samples = val[0];
				default: ;
			endcase
		endfunction

		function int unsigned row_count();
			int unsigned h;
			h = cfg.view_height;
			if (h < 1) h = 1;
			if (h > 4096) h = 4096;
			return h;
		endfunction

		function int unsigned level_of_sample(logic [15:0] v);
			int unsigned u;
			if (cfg.wide_samples) begin
				u = v ^ 16'h8000;
				return (u * row_count()) >> 16;
			end
			u = v[7:0] ^ 8'h80;
			return (u * row_count()) >> 8;
		endfunction

		function longint unsigned take_step();
			longint unsigned z;
			longint unsigned t;
			z = cfg.zoom_step;
			if (z < ZOOM_FLOOR) z = ZOOM_FLOOR;
			frac_acc += z & (FRAC_ONE - 1);
			t = z >> 24;
			if (frac_acc >= FRAC_ONE) begin
				frac_acc -= FRAC_ONE;
				t++;
			end
			if (t > INDEX_MASK) t = INDEX_MASK;
			return t;
		endfunction

		function void close_column();
			int unsigned h;
			int unsigned top;
			int unsigned bot;
			h = row_count();
			top = h - 1 - lvl_hi;
			bot = h - 1 - lvl_lo;
			if (have_held) spans_due.push_back(held);
			held.column = cols_done[11:0];
			held.row_top = top[11:0];
			held.row_bottom = bot[11:0];
			held.end_of_run = 1'b0;
			have_held = 1;
			cols_done++;
		endfunction

		function void note_sample(logic [15:0] v, logic fin);
			longint unsigned s;
			longint unsigned first;
			longint unsigned t;
			longint unsigned w;
			int unsigned lv;
			s = smp_idx;
			lv = level_of_sample(v);
			w = cfg.view_width;
			if (w > COLS_CAP) w = COLS_CAP;
			if (!frame_done) begin
				if (col_open) begin
					if (lv < lvl_lo) lvl_lo = lv;
					if (lv > lvl_hi) lvl_hi = lv;
					if (s == col_end) begin
						close_column();
						col_open = 0;
					end
				end
				while (!col_open && cols_done < w) begin
					first = (cols_done == 0) ? (cfg.start_position & INDEX_MASK) : col_end;
					if (s != first) break;
					lvl_lo = lv;
					lvl_hi = lv;
					t = take_step();
					col_end = s + t;
					if (t == 0) close_column();
					else col_open = 1;
				end
				if (cols_done >= w) frame_done = 1;
			end
			if (fin) begin
				if (col_open && !frame_done) close_column();
				clear_frame();
			end else begin
				smp_idx = (s + 1) & INDEX_MASK;
			end
			if (have_held) begin
				held.end_of_run = 1'b1;
				spans_due.push_back(held);
				have_held = 0;
			end
		endfunction

		function void report(string field, logic [11:0] want, logic [11:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_span(logic [11:0] c, logic [11:0] top, logic [11:0] bot, logic eor);
			span_t want;
			if (spans_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected span, expected none, actual column %0d top %0d bottom %0d",
					$time, c, top, bot);
				return;
			end
			want = spans_due.pop_front();
			if (c !== want.column) report("column", want.column, c);
			if (top !== want.row_top) report("row_top", want.row_top, top);
			if (bot !== want.row_bottom) report("row_bottom", want.row_bottom, bot);
			if (eor !== want.end_of_run) report("end_of_run", want.end_of_run, eor);
		endfunction

		function int pending();
			return spans_due.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [15:0]       sample_value;
	logic              final_sample;
	logic              out_valid;
	logic              out_ready;
	logic [ROW_W-1:0]  column;
	logic [ROW_W-1:0]  row_top;
	logic [ROW_W-1:0]  row_bottom;
	logic              end_of_run;

	span_scoreboard sb;
	int             samples_sent;
	bit             tx_burst;
	bit             rx_burst;
	int             stall_cycles;

	waveform_column_span_render u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.final_sample (final_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column       (column),
		.row_top      (row_top),
		.row_bottom   (row_bottom),
		.end_of_run   (end_of_run)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apply_cfg(input logic [23:0] start, input logic [47:0] zoom,
			input logic [12:0] width, input logic [12:0] height, input logic wide);
		settle();
		write_reg(REG_START, 64'(start));
		write_reg(REG_ZOOM, 64'(zoom));
		write_reg(REG_WIDTH, 64'(width));
		write_reg(REG_HEIGHT, 64'(height));
		write_reg(REG_WIDE, 64'(wide));
	endtask

	task automatic send_sample(input logic [15:0] v, input logic fin);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= v;
		final_sample <= fin;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_sample(v, fin);
		samples_sent++;
		@(negedge clk);
	endtask

	function automatic logic [15:0] random_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h8000;
		if (r == 1) return 16'h7FFF;
		return 16'($urandom);
	endfunction

	task automatic send_waveform(input int len);
		int i;
		tx_burst = ($urandom_range(0, 3) == 0);
		for (i = 0; i < len; i++) send_sample(random_sample(), i == len - 1);
	endtask

	// receiver with random stalls and one long hold-off
	initial begin : drain_spans
		int gap;
		int beats;
		int hold;
		bit held_off;
		beats = 0;
		held_off = 0;
		rx_burst = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!held_off && beats >= 60 && in_valid === 1'b1 && sb.pending() >= 2) begin
				held_off = 1;
				out_ready <= 1'b0;
				for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clk);
			end
			gap = rx_burst ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_span(column, row_top, row_bottom, end_of_run);
			beats++;
			if (beats % 20 == 0) rx_burst = ($urandom_range(0, 3) == 0);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		int r;
		int waves;
		int j;
		logic [23:0] start;
		logic [47:0] zoom;
		logic [12:0] width;
		logic [12:0] height;
		sb = new();
		samples_sent = 0;
		tx_burst = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample_value = '0;
		final_sample = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, one span per sample, partial span at the end
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h1234, 1'b1);

		// narrow samples, zero height, zoom below floor, skipped lead-in, frame full
		apply_cfg(24'd2, 48'd0, 13'd3, 13'd0, 1'b0);
		send_sample(16'h0080, 1'b0);
		send_sample(16'h007F, 1'b0);
		send_sample(16'hFF80, 1'b0);
		send_sample(16'h1200, 1'b0);
		send_sample(16'h00FF, 1'b1);

		// saturated step, column never closes, oversized width and height
		apply_cfg(24'd0, 48'hFFFF_FFFF_FFFF, 13'h1FFF, 13'h1FFF, 1'b1);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hC000, 1'b0);
		send_sample(16'h4000, 1'b1);

		// start beyond the stream, every sample skipped
		apply_cfg(24'hFF_FFFF, 48'h1_800000, 13'd4096, 13'd4096, 1'b0);
		send_sample(16'h1234, 1'b0);
		send_sample(16'hFEDC, 1'b0);
		send_sample(16'h0F0F, 1'b1);

		// zero width
		apply_cfg(24'd0, 48'h07_FFFF, 13'd0, 13'd1, 1'b1);
		send_sample(16'h2222, 1'b0);
		send_sample(16'hDDDD, 1'b1);

		// smallest zoom, one sample fans out to many columns
		apply_cfg(24'd1, 48'h08_0000, 13'd40, 13'd4096, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h8001, 1'b0);
		send_sample(16'h7FFE, 1'b1);

		while (samples_sent < SAMPLE_TARGET) begin
			r = $urandom_range(0, 9);
			if (r < 7) start = $urandom_range(0, 12);
			else if (r < 9) start = $urandom_range(0, 40);
			else start = 24'($urandom);
			r = $urandom_range(0, 9);
			if (r < 3) zoom = 48'($urandom_range(0, 24'hFF_FFFF));
			else if (r < 7) zoom = 48'($urandom_range(1, 4)) << 24 | 48'($urandom_range(0, 24'hFF_FFFF));
			else if (r < 9) zoom = 48'($urandom_range(0, 8)) << 24;
			else zoom = 48'({$urandom, $urandom});
			r = $urandom_range(0, 9);
			if (r == 0) width = 13'd0;
			else if (r == 1) width = 13'($urandom_range(4096, 8191));
			else width = 13'($urandom_range(1, 48));
			r = $urandom_range(0, 3);
			if (r == 0) height = 13'($urandom_range(0, 16));
			else height = 13'($urandom_range(0, 8191));
			apply_cfg(start, zoom, width, height, 1'($urandom_range(0, 1)));
			waves = $urandom_range(1, 3);
			for (j = 0; j < waves; j++) send_waveform($urandom_range(1, 40));
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
